>>> rtl/llre_pkg.sv
`timescale 1ns / 1ps

package llre_pkg;

	localparam int OP_W  = 3;
	localparam int BOX_W = 11;
	localparam int SUM_W = 20;

	localparam int MAX_BOXES_DEF = 1024;
	localparam int BOX_COUNT_RST = 1024;

	localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
	localparam logic [OP_W-1:0] OP_LEFT    = 3'd1;
	localparam logic [OP_W-1:0] OP_RIGHT   = 3'd2;
	localparam logic [OP_W-1:0] OP_SWAP    = 3'd3;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
	localparam logic [OP_W-1:0] OP_REPORT  = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [BOX_W-1:0] box_a;
		logic [BOX_W-1:0] box_b;
	} cmd_t;

endpackage

>>> rtl/llre_link_ram.sv
`timescale 1ns / 1ps

module llre_link_ram #(
	parameter int DEPTH = 1025,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/llre_seq.sv
`timescale 1ns / 1ps

module llre_seq import llre_pkg::*; #(
	parameter int MAX_BOXES = MAX_BOXES_DEF,
	localparam int AW = $clog2(MAX_BOXES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	input  logic [AW-1:0]    n_eff,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [SUM_W-1:0] res_sum,
	output logic             nxt_we,
	output logic [AW-1:0]    nxt_waddr,
	output logic [AW-1:0]    nxt_wdata,
	output logic [AW-1:0]    nxt_raddr,
	input  logic [AW-1:0]    nxt_rdata,
	output logic             prv_we,
	output logic [AW-1:0]    prv_waddr,
	output logic [AW-1:0]    prv_wdata,
	output logic [AW-1:0]    prv_raddr,
	input  logic [AW-1:0]    prv_rdata
);

	localparam int TW = (2 * AW + 2 > SUM_W + 1) ? 2 * AW + 2 : SUM_W + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_INIT = 7'b0000010,
		ST_RDY  = 7'b0000100,
		ST_CAP  = 7'b0001000,
		ST_WR   = 7'b0010000,
		ST_WALK = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	// SW_ANY: swap whose adjacency is not known until both link pairs are in
	typedef enum logic [2:0] {
		MV_LEFT,
		MV_RIGHT,
		SW_ANY,
		SW_ADJ,
		SW_FAR
	} kind_t;

	state_t          state_q;
	kind_t           kind_q;
	logic            rev_q;
	logic [AW-1:0]   ls_q;
	logic [AW-1:0]   a_q, b_q, pa_q, na_q, pb_q, nb_q;
	logic [1:0]      step_q;
	logic [AW-1:0]   cnt_q;
	logic [SUM_W-1:0] sum_q, tri_q;

	logic            accept;
	logic            box_bad;
	logic [AW-1:0]   walk_pos;
	logic [TW-1:0]   n_ext, tri_prod;
	logic [AW-1:0]   join_u, join_v;
	logic [1:0]      last_step;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	assign box_bad = (cmd.box_a == '0) || (cmd.box_b == '0) || (cmd.box_a == cmd.box_b)
		|| ({{(32-BOX_W){1'b0}}, cmd.box_a} > {{(32-AW){1'b0}}, ls_q})
		|| ({{(32-BOX_W){1'b0}}, cmd.box_b} > {{(32-AW){1'b0}}, ls_q});

	// links above the table range only come from never-written entries
	assign walk_pos = ({{(32-AW){1'b0}}, nxt_rdata} > 32'(MAX_BOXES)) ? '0 : nxt_rdata;

	assign n_ext    = TW'(n_eff);
	assign tri_prod = n_ext * (n_ext + TW'(1));

	assign res_valid = (state_q == ST_DONE);
	assign res_sum   = (rev_q && !n_eff[0]) ? (tri_q - sum_q) : sum_q;

	assign last_step = (kind_q == SW_FAR) ? 2'd3 : 2'd2;

	// every write step is one join(u, v): next[u] = v, prev[v] = u
	always_comb begin
		join_u = a_q;
		join_v = nb_q;
		case (kind_q)
			MV_LEFT: begin
				case (step_q)
					2'd0: begin join_u = pa_q; join_v = na_q; end
					2'd1: begin join_u = pb_q; join_v = a_q;  end
					default: begin join_u = a_q; join_v = b_q; end
				endcase
			end
			MV_RIGHT: begin
				case (step_q)
					2'd0: begin join_u = pa_q; join_v = na_q; end
					2'd1: begin join_u = b_q;  join_v = a_q;  end
					default: begin join_u = a_q; join_v = nb_q; end
				endcase
			end
			SW_ADJ: begin
				case (step_q)
					2'd0: begin join_u = pa_q; join_v = b_q; end
					2'd1: begin join_u = b_q;  join_v = a_q; end
					default: begin join_u = a_q; join_v = nb_q; end
				endcase
			end
			SW_FAR: begin
				case (step_q)
					2'd0: begin join_u = pa_q; join_v = b_q;  end
					2'd1: begin join_u = b_q;  join_v = na_q; end
					2'd2: begin join_u = pb_q; join_v = a_q;  end
					default: begin join_u = a_q; join_v = nb_q; end
				endcase
			end
			default: begin
				join_u = a_q;
				join_v = nb_q;
			end
		endcase
	end

	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = join_u;
		nxt_wdata = join_v;
		prv_we    = 1'b0;
		prv_waddr = join_v;
		prv_wdata = join_u;
		nxt_raddr = AW'(cmd.box_a);
		prv_raddr = AW'(cmd.box_a);
		case (state_q)
			ST_IDLE: begin
				if (cmd.opcode == OP_REPORT) begin
					nxt_raddr = '0;
				end
			end
			ST_INIT: begin
				nxt_we    = 1'b1;
				nxt_waddr = cnt_q;
				nxt_wdata = (cnt_q == n_eff) ? '0 : cnt_q + AW'(1);
				prv_we    = 1'b1;
				prv_waddr = cnt_q;
				prv_wdata = (cnt_q == '0) ? n_eff : cnt_q - AW'(1);
			end
			ST_RDY: begin
				nxt_raddr = b_q;
				prv_raddr = b_q;
			end
			ST_WR: begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			ST_WALK: begin
				nxt_raddr = walk_pos;
			end
			default: begin
				nxt_raddr = AW'(cmd.box_a);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rev_q   <= 1'b0;
			ls_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							OP_INIT: begin
								ls_q    <= n_eff;
								rev_q   <= 1'b0;
								state_q <= ST_INIT;
							end
							OP_LEFT, OP_RIGHT, OP_SWAP: begin
								if (!box_bad) begin
									state_q <= ST_RDY;
								end
							end
							OP_REVERSE: rev_q <= ~rev_q;
							OP_REPORT: state_q <= ST_WALK;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INIT: begin
					if (cnt_q == n_eff) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDY: state_q <= ST_CAP;
				ST_CAP: begin
					if ((kind_q == MV_LEFT && na_q == b_q)
						|| (kind_q == MV_RIGHT && nxt_rdata == a_q)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (step_q == last_step) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (cnt_q == n_eff) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q    <= AW'(cmd.box_a);
				b_q    <= AW'(cmd.box_b);
				step_q <= 2'd0;
				sum_q  <= '0;
				tri_q  <= tri_prod[SUM_W:1];
				cnt_q  <= (cmd.opcode == OP_REPORT) ? AW'(1) : '0;
				// reversed view swaps the two move kinds
				case (cmd.opcode)
					OP_LEFT:  kind_q <= rev_q ? MV_RIGHT : MV_LEFT;
					OP_RIGHT: kind_q <= rev_q ? MV_LEFT : MV_RIGHT;
					default:  kind_q <= SW_ANY;
				endcase
			end
			ST_INIT: cnt_q <= cnt_q + AW'(1);
			ST_RDY: begin
				na_q <= nxt_rdata;
				pa_q <= prv_rdata;
			end
			ST_CAP: begin
				if (kind_q == SW_ANY && nxt_rdata == a_q) begin
					// y sits just left of x: exchange roles so x leads
					a_q    <= b_q;
					b_q    <= a_q;
					pa_q   <= prv_rdata;
					na_q   <= nxt_rdata;
					pb_q   <= pa_q;
					nb_q   <= na_q;
					kind_q <= SW_ADJ;
				end else begin
					pb_q <= prv_rdata;
					nb_q <= nxt_rdata;
					if (kind_q == SW_ANY) begin
						kind_q <= (na_q == b_q) ? SW_ADJ : SW_FAR;
					end
				end
			end
			ST_WR: step_q <= step_q + 2'd1;
			ST_WALK: begin
				if (cnt_q[0]) begin
					sum_q <= sum_q + SUM_W'(walk_pos);
				end
				cnt_q <= cnt_q + AW'(1);
			end
			default: step_q <= step_q;
		endcase
	end

endmodule

>>> rtl/linked_list_reorder_engine_top.sv
`timescale 1ns / 1ps

// Box reorder engine: boxes 1..n on a ring of next/prev links held in two
// one-port-read, one-port-write RAMs, slot 0 closing the ring. Send init
// first; moves and swaps before that are dropped. In a move or swap the
// link pairs of X and then of Y are read from registered-output RAMs, then
// one join is written per cycle, three for a move or an adjacent swap, four
// for any other swap. A move that finds X already in place ends after the
// reads; a move or swap naming a bad or repeated box is dropped.
// Init writes one ring entry per cycle in both RAMs.
// Report walks the chain of dependent next-link reads, one per cycle, then
// waits while the output register still holds an untaken word. A report
// word sits in an output register, so the next item is taken meanwhile.
// box_count may be written only while the engine is idle.
module linked_list_reorder_engine_top import llre_pkg::*; #(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [BOX_W-1:0] box_count,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  opcode,
	input  logic [BOX_W-1:0] box_a,
	input  logic [BOX_W-1:0] box_b,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SUM_W-1:0] odd_position_sum
);

	localparam int AW      = $clog2(MAX_BOXES + 1);
	localparam int N_RST_I = (BOX_COUNT_RST > MAX_BOXES) ? MAX_BOXES : BOX_COUNT_RST;

	logic [AW-1:0]    n_q, n_clamped;
	logic             out_valid_q;
	logic [SUM_W-1:0] sum_q;
	cmd_t             cmd;
	logic             res_valid, res_ready;
	logic [SUM_W-1:0] res_sum;
	logic             nxt_we, prv_we;
	logic [AW-1:0]    nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
	logic [AW-1:0]    prv_waddr, prv_wdata, prv_raddr, prv_rdata;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (box_count == '0) begin
			n_clamped = AW'(1);
		end else if ({{(32-BOX_W){1'b0}}, box_count} > 32'(MAX_BOXES)) begin
			n_clamped = AW'(MAX_BOXES);
		end else begin
			n_clamped = AW'(box_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= AW'(N_RST_I);
		end else if (cfg_valid && cfg_ready) begin
			n_q <= n_clamped;
		end
	end

	assign cmd.opcode = opcode;
	assign cmd.box_a  = box_a;
	assign cmd.box_b  = box_b;

	// output word register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			sum_q <= res_sum;
		end
	end

	assign out_valid        = out_valid_q;
	assign odd_position_sum = sum_q;

	llre_seq #(
		.MAX_BOXES(MAX_BOXES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(in_valid),
		.cmd_ready(in_ready),
		.cmd      (cmd),
		.n_eff    (n_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_sum  (res_sum),
		.nxt_we   (nxt_we),
		.nxt_waddr(nxt_waddr),
		.nxt_wdata(nxt_wdata),
		.nxt_raddr(nxt_raddr),
		.nxt_rdata(nxt_rdata),
		.prv_we   (prv_we),
		.prv_waddr(prv_waddr),
		.prv_wdata(prv_wdata),
		.prv_raddr(prv_raddr),
		.prv_rdata(prv_rdata)
	);

	llre_link_ram #(
		.DEPTH(MAX_BOXES + 1)
	) u_next_ram (
		.clk  (clk),
		.we   (nxt_we),
		.waddr(nxt_waddr),
		.wdata(nxt_wdata),
		.raddr(nxt_raddr),
		.rdata(nxt_rdata)
	);

	llre_link_ram #(
		.DEPTH(MAX_BOXES + 1)
	) u_prev_ram (
		.clk  (clk),
		.we   (prv_we),
		.waddr(prv_waddr),
		.wdata(prv_wdata),
		.raddr(prv_raddr),
		.rdata(prv_rdata)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import llre_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam int SETTLE = MAX_BOXES_DEF + 16;
	localparam int QUIET_LIMIT = 20000;
	localparam int N_PHASES = 16;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [BOX_W-1:0] box_count = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [OP_W-1:0]  opcode = OP_INIT;
	logic [BOX_W-1:0] box_a = '0;
	logic [BOX_W-1:0] box_b = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [SUM_W-1:0] odd_position_sum;

	linked_list_reorder_engine_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.box_count        (box_count),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.box_a            (box_a),
		.box_b            (box_b),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.odd_position_sum (odd_position_sum)
	);

	// ring image kept alongside the engine
	bit [BOX_W-1:0] nxt_link [0:MAX_BOXES_DEF];
	bit [BOX_W-1:0] prv_link [0:MAX_BOXES_DEF];
	bit             flipped = 1'b0;
	int unsigned    ring_len = 0;
	bit [BOX_W-1:0] count_reg = BOX_W'(BOX_COUNT_RST);

	logic [SUM_W-1:0] expected_sums [$];
	cmd_t             cmd_backlog [$];

	// stimulus side view of the list size
	int unsigned plan_len = 0;
	int unsigned plan_cfg = BOX_COUNT_RST;
	bit          calm = 1'b0;
	int          err_count = 0;
	int          gap_left;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned clamp_count(int unsigned v);
		if (v < 1) return 1;
		if (v > MAX_BOXES_DEF) return MAX_BOXES_DEF;
		return v;
	endfunction

	function automatic void tie(int unsigned a, int unsigned b);
		nxt_link[a] = BOX_W'(b);
		prv_link[b] = BOX_W'(a);
	endfunction

	function automatic void swap_boxes(int unsigned x, int unsigned y);
		int unsigned t, px, nx, py, ny;
		// put x on the left when the pair is adjacent the other way round
		if (32'(nxt_link[y]) == x) begin
			t = x;
			x = y;
			y = t;
		end
		px = 32'(prv_link[x]);
		nx = 32'(nxt_link[x]);
		py = 32'(prv_link[y]);
		ny = 32'(nxt_link[y]);
		if (nx == y) begin
			tie(px, y);
			tie(y, x);
			tie(x, ny);
		end else begin
			tie(px, y);
			tie(y, nx);
			tie(py, x);
			tie(x, ny);
		end
	endfunction

	task automatic ring_apply(input logic [OP_W-1:0] op, input int unsigned x,
		input int unsigned y);
		int unsigned n, pos, aft;
		logic [63:0] acc;
		n = clamp_count(32'(count_reg));
		if (op == OP_INIT) begin
			for (int unsigned i = 0; i <= n; i++) begin
				prv_link[i] = (i == 0) ? BOX_W'(n) : BOX_W'(i - 1);
				nxt_link[i] = (i == n) ? '0 : BOX_W'(i + 1);
			end
			ring_len = n;
			flipped = 1'b0;
		end else if (op == OP_REVERSE) begin
			flipped = !flipped;
		end else if (op == OP_REPORT) begin
			acc = '0;
			pos = 0;
			// sentinel counts as zero when n exceeds the ring
			for (int unsigned i = 1; i <= n; i++) begin
				pos = 32'(nxt_link[pos]);
				if (pos > MAX_BOXES_DEF) pos = 0;
				if (i % 2) acc += 64'(pos);
			end
			if (flipped && (n % 2 == 0)) acc = (64'(n) * 64'(n + 1)) / 64'(2) - acc;
			expected_sums.push_back(acc[SUM_W-1:0]);
		end else if (op == OP_LEFT || op == OP_RIGHT || op == OP_SWAP) begin
			if (x != 0 && y != 0 && x <= ring_len && y <= ring_len && x != y) begin
				if (op != OP_SWAP && flipped) op = (op == OP_LEFT) ? OP_RIGHT : OP_LEFT;
				if (op == OP_LEFT) begin
					if (32'(nxt_link[x]) != y) begin
						tie(32'(prv_link[x]), 32'(nxt_link[x]));
						tie(32'(prv_link[y]), x);
						tie(x, y);
					end
				end else if (op == OP_RIGHT) begin
					if (32'(nxt_link[y]) != x) begin
						tie(32'(prv_link[x]), 32'(nxt_link[x]));
						aft = 32'(nxt_link[y]);
						tie(y, x);
						tie(x, aft);
					end
				end else begin
					swap_boxes(x, y);
				end
			end
		end
	endtask

	task automatic flag_error(input string msg);
		err_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		logic nv;
		cmd_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_INIT;
			box_a <= '0;
			box_b <= '0;
			gap_left = 0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				ring_apply(opcode, 32'(box_a), 32'(box_b));
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 9);
				end else if (cmd_backlog.size() > 0) begin
					c = cmd_backlog.pop_front();
					opcode <= c.opcode;
					box_a <= c.box_a;
					box_b <= c.box_b;
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	always @(posedge clk or negedge arst_n) begin : sum_checker
		logic r;
		logic [SUM_W-1:0] want;
		int stall_left, hold_left, sums_seen;
		bit held_once;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			sums_seen = 0;
			held_once = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					flag_error($sformatf("sum %0d with none pending", odd_position_sum));
				end else begin
					want = expected_sums.pop_front();
					if (odd_position_sum !== want)
						flag_error($sformatf("odd_position_sum %0d, want %0d",
							odd_position_sum, want));
				end
				sums_seen++;
			end
			r = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				r = 1'b0;
			end else if (!held_once && !calm && sums_seen >= 30 && out_valid) begin
				// long back-pressure so the engine fills and stalls its input
				hold_left = 299;
				held_once = 1'b1;
				r = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				r = 1'b0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 9);
				r = 1'b0;
			end
			out_ready <= r;
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("linked_list_reorder_engine_top regression: fail");
				$finish;
			end
		end
	end

	task automatic push_cmd(input logic [OP_W-1:0] op, input int unsigned a,
		input int unsigned b);
		cmd_t c;
		c.opcode = op;
		c.box_a = BOX_W'(a);
		c.box_b = BOX_W'(b);
		if (op == OP_INIT) plan_len = clamp_count(plan_cfg);
		cmd_backlog.push_back(c);
	endtask

	function automatic int unsigned pick_box(int unsigned len);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 2047;
			2: return $urandom_range(len + 1, 2047);
			default: return $urandom_range(1, len);
		endcase
	endfunction

	task automatic push_random();
		int unsigned r, a, b, ja, jb;
		r = $urandom_range(0, 99);
		a = pick_box(plan_len);
		b = ($urandom_range(0, 15) == 0) ? a : pick_box(plan_len);
		ja = $urandom_range(0, 2047);
		jb = $urandom_range(0, 2047);
		if (r < 4) push_cmd(OP_INIT, ja, jb);
		else if (r < 7) push_cmd($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, ja, jb);
		else if (r < 17) push_cmd(OP_REVERSE, ja, jb);
		else if (r < 37) push_cmd(OP_REPORT, ja, jb);
		else if (r < 60) push_cmd(OP_LEFT, a, b);
		else if (r < 83) push_cmd(OP_RIGHT, a, b);
		else push_cmd(OP_SWAP, a, b);
	endtask

	// list of six: 1 2 3 4 5 6 after init
	task automatic push_directed();
		push_cmd(OP_LEFT, 1, 2);     // dropped, nothing initialized yet
		push_cmd(OP_SWAP, 3, 4);
		push_cmd(OP_REVERSE, 0, 0);  // init has to clear this
		push_cmd(OP_INIT, 2047, 2047);
		push_cmd(OP_REPORT, 0, 0);
		push_cmd(OP_LEFT, 1, 3);
		push_cmd(OP_LEFT, 1, 3);     // already left of 3
		push_cmd(OP_RIGHT, 6, 2);
		push_cmd(OP_RIGHT, 6, 2);
		push_cmd(OP_SWAP, 1, 3);     // neighbors
		push_cmd(OP_SWAP, 1, 3);     // neighbors, other order
		push_cmd(OP_SWAP, 2, 5);
		push_cmd(OP_LEFT, 4, 4);
		push_cmd(OP_SWAP, 4, 4);
		push_cmd(OP_LEFT, 0, 3);
		push_cmd(OP_SWAP, 7, 1);
		push_cmd(OP_LEFT, 1024, 1);
		push_cmd(OP_REPORT, 0, 0);
		push_cmd(OP_REVERSE, 0, 0);
		push_cmd(OP_REPORT, 0, 0);   // even n, complemented
		push_cmd(OP_LEFT, 4, 2);
		push_cmd(OP_RIGHT, 1, 5);
		push_cmd(OP_SWAP, 6, 4);
		push_cmd(OP_REPORT, 0, 0);
		push_cmd(OP_REVERSE, 0, 0);
		push_cmd(OP_SPARE6, 2047, 0);
		push_cmd(OP_SPARE7, 1, 2047);
		push_cmd(OP_REPORT, 2047, 2047);
	endtask

	task automatic phase_plan(input int p, output int unsigned cfg_v,
		output int unsigned n_items, output bit keep);
		keep = 1'b0;
		case (p)
			0:  begin cfg_v = 6;    n_items = 150; end
			1:  begin cfg_v = 1;    n_items = 60;  keep = 1'b1; end
			2:  begin cfg_v = 0;    n_items = 40;  end
			3:  begin cfg_v = 2;    n_items = 80;  end
			4:  begin cfg_v = 2047; n_items = 30;  end
			5:  begin cfg_v = 3;    n_items = 100; keep = 1'b1; end
			6:  begin cfg_v = 9;    n_items = 150; end
			7:  begin cfg_v = 1024; n_items = 30;  end
			8:  begin cfg_v = 12;   n_items = 150; end
			9:  begin cfg_v = 5;    n_items = 120; end
			10: begin cfg_v = 40;   n_items = 80;  end
			11: begin cfg_v = 4;    n_items = 120; end
			12: begin cfg_v = 1500; n_items = 20;  keep = 1'b1; end
			13: begin cfg_v = 7;    n_items = 150; end
			14: begin cfg_v = 8;    n_items = 150; end
			default: begin cfg_v = 11; n_items = 120; end
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (cmd_backlog.size() != 0 || in_valid || expected_sums.size() != 0);
	endtask

	task automatic write_cfg(input int unsigned v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		box_count <= BOX_W'(v);
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		count_reg = BOX_W'(v);
		plan_cfg = v;
	endtask

	initial begin : stimulus
		int unsigned cfg_v, n_items;
		bit keep;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < N_PHASES; p++) begin
			phase_plan(p, cfg_v, n_items, keep);
			wait_drained();
			// engine may still be busy on an init or move with no word out
			repeat (SETTLE) @(posedge clk);
			if (p == N_PHASES - 1) calm = 1'b1;
			write_cfg(cfg_v);
			if (p == 0) push_directed();
			if (!keep) push_cmd(OP_INIT, $urandom_range(0, 2047), $urandom_range(0, 2047));
			for (int k = 0; k < n_items; k++) begin
				if (p == 3 && k == n_items / 2) wait_drained();
				push_random();
			end
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("linked_list_reorder_engine_top regression: pass");
		else
			$display("linked_list_reorder_engine_top regression: fail");
		$finish;
	end

endmodule
